[hw/rtl/cgc_pkg.sv]
// Shared constants and types for the constraint group coloring block.
`timescale 1ns / 1ps
`default_nettype none
package cgc_pkg;

    // Sizing of the coloring problem.
    localparam int MAX_PARTICLES = 4096;
    localparam int MAX_GROUPS    = 64;
    localparam int MAX_BODIES    = 4;

    // Fixed field widths of the request and result channels.
    localparam int PART_W  = 12;
    localparam int BODY_W  = 3;
    localparam int NUM_W   = 16;
    localparam int GROUP_W = 6;

    // Derived widths.
    localparam int ADDR_W    = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
    localparam int GRP_IDX_W = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int SLOT_W    = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;

    // Epoch tag kept next to every mask word; a start bumps the epoch so
    // stale words read as empty. A sweep runs after reset and when the epoch wraps.
    localparam int EPOCH_W = 8;
    localparam int MEM_W   = EPOCH_W + MAX_GROUPS;

    // Result of the lowest-free-group search.
    typedef struct packed {
        logic                 over;
        logic [GRP_IDX_W-1:0] group;
    } cgc_find_t;

endpackage
`default_nettype wire

[hw/rtl/cgc_if.sv]
// Request and result channel interfaces of the constraint group coloring block.
`timescale 1ns / 1ps
`default_nettype none
interface cgc_in_if;
    logic                      valid;
    logic                      ready;
    logic                      start_new;
    logic [cgc_pkg::BODY_W-1:0] body_count;
    logic [cgc_pkg::PART_W-1:0] particle_a;
    logic [cgc_pkg::PART_W-1:0] particle_b;
    logic [cgc_pkg::PART_W-1:0] particle_c;
    logic [cgc_pkg::PART_W-1:0] particle_d;

    modport source (
        output valid, start_new, body_count, particle_a, particle_b, particle_c, particle_d,
        input  ready
    );
    modport sink (
        input  valid, start_new, body_count, particle_a, particle_b, particle_c, particle_d,
        output ready
    );
endinterface

interface cgc_out_if;
    logic                        valid;
    logic                        ready;
    logic [cgc_pkg::NUM_W-1:0]   constraint_number;
    logic [cgc_pkg::GROUP_W-1:0] group_index;
    logic                        overflow;

    modport source (
        output valid, constraint_number, group_index, overflow,
        input  ready
    );
    modport sink (
        input  valid, constraint_number, group_index, overflow,
        output ready
    );
endinterface
`default_nettype wire

[hw/rtl/cgc_mask_ram.sv]
// Single-port synchronous RAM holding the tagged per-particle group masks.
`timescale 1ns / 1ps
`default_nettype none
module cgc_mask_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 72
) (
    input  wire logic                       clk,
    input  wire logic                       en,
    input  wire logic                       we,
    input  wire logic [$clog2(DEPTH)-1:0]   addr,
    input  wire logic [WIDTH-1:0]           wdata,
    output logic      [WIDTH-1:0]           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule
`default_nettype wire

[hw/rtl/cgc_group_find.sv]
// Two-stage search for the lowest group that no particle occupies.
`timescale 1ns / 1ps
`default_nettype none
module cgc_group_find (
    input  wire logic                           clk,
    input  wire logic [cgc_pkg::MAX_GROUPS-1:0] busy,
    output cgc_pkg::cgc_find_t                  result
);
    import cgc_pkg::*;

    logic [MAX_GROUPS-1:0] free;
    logic [MAX_GROUPS-1:0] lowest_reg;
    logic                  over_reg;
    logic [GRP_IDX_W-1:0]  group_next;
    cgc_find_t             result_reg;

    assign free = ~busy;

    // stage 1: isolate lowest set bit
    always_ff @(posedge clk)
    begin
        lowest_reg <= free & (~free + {{(MAX_GROUPS-1){1'b0}}, 1'b1});
        over_reg   <= (free == '0);
    end

    // stage 2: encode the one-hot word
    always_comb
    begin
        group_next = '0;
        for (int i = 0; i < MAX_GROUPS; i++)
        begin
            if (lowest_reg[i])
            begin
                group_next = group_next | GRP_IDX_W'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg.over  <= over_reg;
        result_reg.group <= group_next;
    end

    assign result = result_reg;

endmodule
`default_nettype wire

[hw/rtl/constraint_group_coloring.sv]
// Top level of the constraint group coloring block: sequencer around the mask RAM.
`timescale 1ns / 1ps
`default_nettype none
// Usage
//   in_chan  : one request per constraint (start_new, body_count, particle_a..d).
//   out_chan : one result per request (constraint_number, group_index, overflow),
//              delivered in request order.
//   Both channels transfer on a rising edge with valid and ready high.
// Sequence
//   A request is taken only in the idle state. It then does MAX_BODIES reads of
//   the single-port mask RAM, a wait state for the last read, the
//   lowest-free-group search (ST_FIND1, ST_FIND2), MAX_BODIES writes and one
//   result load. The one RAM port is why reads and writes go one slot at a time.
// Reset and start
//   After reset the block sweeps all MAX_PARTICLES words of the RAM, one word
//   per cycle, with ready low. A start request bumps an epoch tag so old words
//   read as empty; every 2**EPOCH_W-th start the tag wraps and the same sweep
//   runs before that request is worked.
// Stall
//   The result sits in an output register. The next request is still taken
//   while it waits; that request then holds in its final step until the
//   receiver takes the pending result.
module constraint_group_coloring (
    input  wire logic  clk,
    input  wire logic  rst_n,
    cgc_in_if.sink     in_chan,
    cgc_out_if.source  out_chan
);
    import cgc_pkg::*;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_RWAIT = 3'd3;
    localparam logic [2:0] ST_FIND1 = 3'd4;
    localparam logic [2:0] ST_FIND2 = 3'd5;
    localparam logic [2:0] ST_WRITE = 3'd6;
    localparam logic [2:0] ST_DONE  = 3'd7;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_BODIES - 1);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_PARTICLES - 1);
    localparam logic [NUM_W-1:0]  NUM_MAX   = '1;

    // control state
    logic [2:0]         state_reg, state_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [ADDR_W-1:0]  clr_addr_reg, clr_addr_next;
    logic               pend_reg, pend_next;
    logic [EPOCH_W-1:0] epoch_reg, epoch_next;
    logic [NUM_W-1:0]   counter_reg, counter_next;
    logic               rd_pend_reg;
    logic               out_valid_reg, out_valid_next;

    // payload of the request in flight
    logic [NUM_W-1:0]      number_reg;
    logic [MAX_BODIES-1:0] used_reg;
    logic [ADDR_W-1:0]     addr_reg [MAX_BODIES];
    logic [MAX_GROUPS-1:0] mask_reg [MAX_BODIES];
    logic [SLOT_W-1:0]     rd_slot_reg;
    logic                  rd_used_reg;

    // result register
    logic [NUM_W-1:0]   out_number_reg;
    logic [GROUP_W-1:0] out_group_reg;
    logic               out_over_reg;

    // request decode
    logic                  in_acc;
    logic [BODY_W-1:0]     count_c;
    logic [PART_W-1:0]     ids [4];
    logic [MAX_BODIES-1:0] used_c;
    logic [NUM_W-1:0]      cnt_base;

    // RAM port
    logic              ram_en;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [MEM_W-1:0]  ram_wdata;
    logic [MEM_W-1:0]  ram_rdata;
    logic [MAX_GROUPS-1:0] rd_mask;

    // search
    logic [MAX_GROUPS-1:0] busy;
    logic [MAX_GROUPS-1:0] grp_bit;
    cgc_find_t             find;
    logic                  out_load;

    assign in_chan.ready = (state_reg == ST_IDLE);
    assign in_acc        = in_chan.valid && in_chan.ready;

    assign ids[0] = in_chan.particle_a;
    assign ids[1] = in_chan.particle_b;
    assign ids[2] = in_chan.particle_c;
    assign ids[3] = in_chan.particle_d;

    // clamp body count, drop particles beyond the array
    assign count_c = (32'(in_chan.body_count) > MAX_BODIES) ? BODY_W'(MAX_BODIES)
                                                           : in_chan.body_count;
    always_comb
    begin
        for (int k = 0; k < MAX_BODIES; k++)
        begin
            used_c[k] = (k < 32'(count_c)) && (32'(ids[k]) < MAX_PARTICLES);
        end
    end

    assign cnt_base = in_chan.start_new ? '0 : counter_reg;

    // a word written under an older epoch counts as empty
    assign rd_mask = (ram_rdata[MEM_W-1 -: EPOCH_W] == epoch_reg)
                   ? ram_rdata[MAX_GROUPS-1:0] : '0;

    always_comb
    begin
        busy = '0;
        for (int k = 0; k < MAX_BODIES; k++)
        begin
            busy = busy | mask_reg[k];
        end
    end

    assign grp_bit  = MAX_GROUPS'(1) << find.group;
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || out_chan.ready);

    // RAM port mux
    always_comb
    begin
        ram_en    = 1'b0;
        ram_we    = 1'b0;
        ram_addr  = addr_reg[slot_reg];
        ram_wdata = {epoch_reg, mask_reg[slot_reg] | grp_bit};
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_en    = 1'b1;
                ram_we    = 1'b1;
                ram_addr  = clr_addr_reg;
                ram_wdata = {epoch_reg, {MAX_GROUPS{1'b0}}};
            end
            ST_READ:
            begin
                ram_en = used_reg[slot_reg];
            end
            ST_WRITE:
            begin
                ram_en = used_reg[slot_reg] && !find.over;
                ram_we = ram_en;
            end
            default:
            begin
                ram_en = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        slot_next     = slot_reg;
        clr_addr_next = clr_addr_reg;
        pend_next     = pend_reg;
        epoch_next    = epoch_reg;
        counter_next  = counter_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == LAST_ADDR)
                begin
                    clr_addr_next = '0;
                    pend_next     = 1'b0;
                    slot_next     = '0;
                    state_next    = pend_reg ? ST_READ : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    counter_next = (cnt_base == NUM_MAX) ? cnt_base : cnt_base + 1'b1;
                    slot_next    = '0;
                    state_next   = ST_READ;
                    if (in_chan.start_new)
                    begin
                        epoch_next = epoch_reg + 1'b1;
                        if (epoch_next == '0)
                        begin
                            // tag wrapped: old words could alias, sweep first
                            pend_next     = 1'b1;
                            clr_addr_next = '0;
                            state_next    = ST_CLEAR;
                        end
                    end
                end
            end
            ST_READ:
            begin
                slot_next = slot_reg + 1'b1;
                if (slot_reg == LAST_SLOT)
                begin
                    slot_next  = '0;
                    state_next = ST_RWAIT;
                end
            end
            ST_RWAIT:
            begin
                state_next = ST_FIND1;
            end
            ST_FIND1:
            begin
                state_next = ST_FIND2;
            end
            ST_FIND2:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                slot_next = slot_reg + 1'b1;
                if (slot_reg == LAST_SLOT)
                begin
                    slot_next  = '0;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_chan.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            slot_reg      <= '0;
            clr_addr_reg  <= '0;
            pend_reg      <= 1'b0;
            epoch_reg     <= '0;
            counter_reg   <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            clr_addr_reg  <= clr_addr_next;
            pend_reg      <= pend_next;
            epoch_reg     <= epoch_next;
            counter_reg   <= counter_next;
            rd_pend_reg   <= (state_reg == ST_READ);
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            number_reg <= cnt_base;
            used_reg   <= used_c;
            for (int k = 0; k < MAX_BODIES; k++)
            begin
                addr_reg[k] <= ADDR_W'(ids[k]);
            end
        end
        rd_slot_reg <= slot_reg;
        rd_used_reg <= used_reg[slot_reg];
        if (rd_pend_reg)
        begin
            mask_reg[rd_slot_reg] <= rd_used_reg ? rd_mask : '0;
        end
        if (out_load)
        begin
            out_number_reg <= number_reg;
            out_group_reg  <= find.over ? '0 : GROUP_W'(find.group);
            out_over_reg   <= find.over;
        end
    end

    assign out_chan.valid             = out_valid_reg;
    assign out_chan.constraint_number = out_number_reg;
    assign out_chan.group_index       = out_group_reg;
    assign out_chan.overflow          = out_over_reg;

    cgc_mask_ram #(
        .DEPTH (MAX_PARTICLES),
        .WIDTH (MEM_W)
    ) u_ram (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    cgc_group_find u_find (
        .clk    (clk),
        .busy   (busy),
        .result (find)
    );

endmodule
`default_nettype wire

[hw/rtl/cgc_checker.sv]
// Port-level checker for the constraint group coloring block, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none
module cgc_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        in_valid,
    input wire logic                        in_ready,
    input wire logic                        out_valid,
    input wire logic                        out_ready,
    input wire logic [cgc_pkg::NUM_W-1:0]   constraint_number,
    input wire logic [cgc_pkg::GROUP_W-1:0] group_index,
    input wire logic                        overflow
);
    import cgc_pkg::*;

    // one request at a time: ready drops right after a request is taken
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while another is in flight");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(constraint_number)
            && $stable(group_index) && $stable(overflow))
        else $error("stalled result changed");

    a_over_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow |-> group_index == '0)
        else $error("overflow result with nonzero group");

    a_group_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> 32'(group_index) < MAX_GROUPS)
        else $error("group index beyond group count");

endmodule

bind constraint_group_coloring cgc_checker u_cgc_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_chan.valid),
    .in_ready          (in_chan.ready),
    .out_valid         (out_chan.valid),
    .out_ready         (out_chan.ready),
    .constraint_number (out_chan.constraint_number),
    .group_index       (out_chan.group_index),
    .overflow          (out_chan.overflow)
);
`default_nettype wire

[test/tb_top.sv]
// Self-checking testbench for the constraint group coloring block.
`timescale 1ns / 1ps
module tb_top;
    import cgc_pkg::*;

    // Ceiling on the whole run. It covers about 1600 requests plus random gaps
    // and stalls, and the RAM clearing passes after reset and on epoch wrap.
    localparam int unsigned CYCLE_LIMIT = 400_000;
    // Random gap odds, in percent, for the request and result sides.
    localparam int unsigned GAP_PCT = 38;
    // Requests in the random part, the number of short start-led sets used
    // to wrap the block's start epoch at least once, and the length of the
    // gap-free stretch.
    localparam int unsigned RANDOM_REQUESTS = 750;
    localparam int unsigned RESTART_SETS = 300;
    localparam int unsigned CALM_REQUESTS = 150;
    // Extra cycles run after the last expected result is taken, so that a stray
    // extra result from the block is still caught.
    localparam int unsigned TAIL_CYCLES = 40;
    // Cap on printed mismatch lines; later ones still count as failures.
    localparam int unsigned MAX_REPORTS = 100;

    typedef struct packed {
        logic              start_new;
        logic [BODY_W-1:0] body_count;
        logic [PART_W-1:0] particle_a;
        logic [PART_W-1:0] particle_b;
        logic [PART_W-1:0] particle_c;
        logic [PART_W-1:0] particle_d;
    } constraint_req_t;

    typedef struct packed {
        logic [NUM_W-1:0]   number;
        logic [GROUP_W-1:0] group;
        logic               over;
    } coloring_t;

    // A request waiting to be driven, with its pacing marks:
    // hold_for_drain - do not present it until every result so far has come
    // calm           - no gaps on either side while it is in flight
    typedef struct {
        constraint_req_t req;
        bit              hold_for_drain;
        bit              calm;
    } queued_req_t;

    logic clk;
    logic rst_n;

    cgc_in_if  req_if ();
    cgc_out_if res_if ();

    constraint_group_coloring dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_chan  (req_if.sink),
        .out_chan (res_if.source)
    );

    // Shadow state of the coloring: one group mask per particle and the
    // sequence counter since the last start.
    logic [63:0]      shadow_masks [MAX_PARTICLES];
    logic [NUM_W-1:0] shadow_number;

    queued_req_t pending_q [$];
    coloring_t   coloring_q [$];

    int unsigned accepted_reqs;
    int unsigned taken_results;
    int unsigned mismatches;
    int unsigned cycle_count;
    bit          rush;

    // ------------------------------------------------------------------
    // Predictor: lowest group free for all used particles, then mark them.
    // ------------------------------------------------------------------
    function automatic coloring_t color_constraint(input constraint_req_t r);
        logic [PART_W-1:0] ids [4];
        int unsigned       used_count;
        logic [63:0]       busy;
        logic [63:0]       limit;
        logic [63:0]       freeset;
        coloring_t         res;
        int                g;

        if (r.start_new)
        begin
            foreach (shadow_masks[i])
                shadow_masks[i] = '0;
            shadow_number = '0;
        end

        // Oversized body counts behave as the maximum.
        used_count = (r.body_count > MAX_BODIES) ? MAX_BODIES : r.body_count;
        ids[0] = r.particle_a;
        ids[1] = r.particle_b;
        ids[2] = r.particle_c;
        ids[3] = r.particle_d;

        busy = '0;
        for (int k = 0; k < used_count; k++)
            if (ids[k] < MAX_PARTICLES)
                busy |= shadow_masks[ids[k]];

        limit   = (MAX_GROUPS >= 64) ? '1 : ((64'd1 << MAX_GROUPS) - 64'd1);
        freeset = ~busy & limit;

        res.over  = (freeset == '0);
        res.group = '0;
        if (!res.over)
        begin
            g = 0;
            while (!freeset[g])
                g++;
            res.group = g[GROUP_W-1:0];
            // Repeated particles simply set the same bit again.
            for (int k = 0; k < used_count; k++)
                if (ids[k] < MAX_PARTICLES)
                    shadow_masks[ids[k]][g] = 1'b1;
        end

        // Sequence number is used up even on overflow; it sticks at all ones.
        res.number = shadow_number;
        if (shadow_number != '1)
            shadow_number = shadow_number + 1'b1;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic add_constraint(input bit start, input int unsigned body,
                                  input int unsigned pa, input int unsigned pb,
                                  input int unsigned pc, input int unsigned pd,
                                  input bit hold = 1'b0, input bit calm = 1'b0);
        queued_req_t q;

        q.req.start_new  = start;
        q.req.body_count = body[BODY_W-1:0];
        q.req.particle_a = pa[PART_W-1:0];
        q.req.particle_b = pb[PART_W-1:0];
        q.req.particle_c = pc[PART_W-1:0];
        q.req.particle_d = pd[PART_W-1:0];
        q.hold_for_drain = hold;
        q.calm           = calm;
        pending_q = {pending_q, q};
    endtask

    // Mostly one to four bodies; now and then none or an oversized count.
    function automatic int unsigned pick_body_count();
        int unsigned roll;

        roll = $urandom_range(0, 99);
        if (roll < 5)
            return 0;
        if (roll < 12)
            return $urandom_range(MAX_BODIES + 1, (1 << BODY_W) - 1);
        return $urandom_range(1, MAX_BODIES);
    endfunction

    // Particle drawn from a small window so masks collide and groups fill.
    function automatic int unsigned pool_pick(input int unsigned base,
                                              input int unsigned span);
        return (base + $urandom_range(0, span - 1)) % (1 << PART_W);
    endfunction

    function automatic int unsigned any_particle();
        return $urandom_range(0, (1 << PART_W) - 1);
    endfunction

    // ------------------------------------------------------------------
    // Mismatch reporting
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string field, input int unsigned want,
                                   input int unsigned got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
    endtask

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Request driver. On acceptance the request is run through the
    // predictor and its expected coloring queued. A new request is only
    // picked up once the current one is gone, so valid never drops while
    // a request waits for ready.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        bit              took;
        bit              present;
        int unsigned     in_flight;
        queued_req_t     nxt;
        constraint_req_t seen;

        if (!rst_n)
        begin
            req_if.valid      <= 1'b0;
            req_if.start_new  <= 1'b0;
            req_if.body_count <= '0;
            req_if.particle_a <= '0;
            req_if.particle_b <= '0;
            req_if.particle_c <= '0;
            req_if.particle_d <= '0;
            accepted_reqs     <= 0;
            rush              <= 1'b0;
        end
        else
        begin
            took = req_if.valid && req_if.ready;
            if (took)
            begin
                seen.start_new  = req_if.start_new;
                seen.body_count = req_if.body_count;
                seen.particle_a = req_if.particle_a;
                seen.particle_b = req_if.particle_b;
                seen.particle_c = req_if.particle_c;
                seen.particle_d = req_if.particle_d;
                coloring_q = {coloring_q, color_constraint(seen)};
            end

            if (!req_if.valid || took)
            begin
                present = 1'b0;
                if (pending_q.size() != 0)
                begin
                    nxt       = pending_q[0];
                    in_flight = accepted_reqs + took - taken_results;
                    if (nxt.hold_for_drain && in_flight != 0)
                        present = 1'b0;
                    else if (!nxt.calm && $urandom_range(0, 99) < GAP_PCT)
                        present = 1'b0;
                    else
                        present = 1'b1;
                end

                if (present)
                begin
                    void'(pending_q.pop_front());
                    req_if.valid      <= 1'b1;
                    req_if.start_new  <= nxt.req.start_new;
                    req_if.body_count <= nxt.req.body_count;
                    req_if.particle_a <= nxt.req.particle_a;
                    req_if.particle_b <= nxt.req.particle_b;
                    req_if.particle_c <= nxt.req.particle_c;
                    req_if.particle_d <= nxt.req.particle_d;
                    rush              <= nxt.calm;
                end
                else
                begin
                    req_if.valid <= 1'b0;
                end
            end
            accepted_reqs <= accepted_reqs + took;
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: compares every taken result with the oldest
    // expectation and throttles ready at random.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        coloring_t want;

        if (!rst_n)
        begin
            res_if.ready  <= 1'b0;
            taken_results <= 0;
        end
        else
        begin
            if (res_if.valid && res_if.ready)
            begin
                if (coloring_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $error("result with no request outstanding: number %0d group %0d",
                               res_if.constraint_number, res_if.group_index);
                end
                else
                begin
                    want = coloring_q.pop_front();
                    if (res_if.constraint_number !== want.number)
                        report_mismatch("constraint_number", want.number,
                                        res_if.constraint_number);
                    if (res_if.group_index !== want.group)
                        report_mismatch("group_index", want.group, res_if.group_index);
                    if (res_if.overflow !== want.over)
                        report_mismatch("overflow", want.over, res_if.overflow);
                end
                taken_results <= taken_results + 1;
            end
            res_if.ready <= rush || ($urandom_range(0, 99) >= GAP_PCT);
        end
    end

    // ------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL constraint_group_coloring");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned generated;
        int unsigned kind;
        int unsigned seq_len;
        int unsigned base;
        int unsigned span;
        int unsigned hot;
        int unsigned slot;
        int unsigned body;
        int unsigned p [4];
        bit          hold;
        bit          calm;

        // Everything the block sees is known from time zero.
        rst_n             = 1'b0;
        cycle_count       = 0;
        mismatches        = 0;
        req_if.valid      = 1'b0;
        req_if.start_new  = 1'b0;
        req_if.body_count = '0;
        req_if.particle_a = '0;
        req_if.particle_b = '0;
        req_if.particle_c = '0;
        req_if.particle_d = '0;
        res_if.ready      = 1'b0;
        foreach (shadow_masks[i])
            shadow_masks[i] = '0;
        shadow_number = '0;

        // Directed opening: field extremes and the corner cases.
        add_constraint(1, 1, 0, 4095, 4095, 4095);    // first after start: group 0
        add_constraint(0, 4, 0, 4095, 1, 2);          // particle 0 busy: group 1
        add_constraint(0, 4, 4095, 4095, 4095, 4095); // same particle four times
        add_constraint(0, 0, 0, 0, 0, 0);             // no bodies: group 0, no marks
        add_constraint(0, 7, 10, 11, 12, 0);          // oversized count reaches slot d
        add_constraint(0, 5, 0, 0, 0, 0);             // oversized, all repeats
        add_constraint(0, 2, 20, 21, 0, 0);           // busy particles in unused slots
        add_constraint(0, 1, 4095, 0, 0, 0);
        add_constraint(1, 3, 0, 1, 2, 4095);          // start mid-stream
        add_constraint(0, 3, 2, 2, 2, 0);
        add_constraint(0, 6, 4095, 4095, 4095, 4095);
        add_constraint(0, 0, 0, 0, 0, 0);
        add_constraint(1, 7, 4095, 4095, 4095, 4095); // all fields at their maximum
        add_constraint(0, 4, 0, 4095, 2048, 1);
        add_constraint(0, 4, 2730, 1365, 0, 4095);

        // Random sequences. Most open with a start and draw from a small
        // particle window so groups pile up; some pin one particle into every
        // constraint to run the 64 groups out.
        generated = 0;
        while (generated < RANDOM_REQUESTS)
        begin
            kind = $urandom_range(0, 99);
            hold = ($urandom_range(0, 99) < 15);
            calm = ($urandom_range(0, 99) < 8);
            base = any_particle();
            if (kind < 50)
            begin
                // Colliding window.
                seq_len = $urandom_range(20, 120);
                span    = $urandom_range(2, 12);
                for (int i = 0; i < seq_len; i++)
                begin
                    for (int k = 0; k < 4; k++)
                        p[k] = pool_pick(base, span);
                    add_constraint(i == 0, pick_body_count(), p[0], p[1], p[2], p[3],
                                   hold && i == 0, calm);
                end
            end
            else if (kind < 70)
            begin
                // One hot particle in every constraint: overflow after 64.
                seq_len = $urandom_range(64, 90);
                span    = $urandom_range(4, 40);
                hot     = any_particle();
                for (int i = 0; i < seq_len; i++)
                begin
                    body = $urandom_range(1, MAX_BODIES);
                    slot = $urandom_range(0, body - 1);
                    for (int k = 0; k < 4; k++)
                        p[k] = pool_pick(base, span);
                    p[slot] = hot;
                    add_constraint(i == 0, body, p[0], p[1], p[2], p[3],
                                   hold && i == 0, calm);
                end
            end
            else if (kind < 90)
            begin
                // Noise: every field at random, starts rare.
                seq_len = $urandom_range(10, 60);
                for (int i = 0; i < seq_len; i++)
                    add_constraint($urandom_range(0, 99) < 3, $urandom_range(0, 7),
                                   any_particle(), any_particle(), any_particle(),
                                   any_particle(), hold && i == 0, calm);
            end
            else
            begin
                // Wide spread over all particles, continuing the last set.
                seq_len = $urandom_range(20, 80);
                for (int i = 0; i < seq_len; i++)
                    add_constraint(0, pick_body_count(), any_particle(), any_particle(),
                                   any_particle(), any_particle(), hold && i == 0, calm);
            end
            generated += seq_len;
        end

        // Many short start-led sets on a tiny window: wraps the start epoch
        // so stale mask words must still read as empty afterwards.
        base = any_particle();
        for (int s = 0; s < RESTART_SETS; s++)
        begin
            seq_len = $urandom_range(0, 2);
            for (int i = 0; i <= seq_len; i++)
            begin
                for (int k = 0; k < 4; k++)
                    p[k] = pool_pick(base, 4);
                add_constraint(i == 0, pick_body_count(), p[0], p[1], p[2], p[3]);
            end
        end

        // Long gap-free stretch: one start, then back to back requests on
        // both sides after the block has drained.
        base = any_particle();
        for (int i = 0; i < CALM_REQUESTS; i++)
        begin
            for (int k = 0; k < 4; k++)
                p[k] = pool_pick(base, 16);
            add_constraint(i == 0, pick_body_count(), p[0], p[1], p[2], p[3], i == 0, 1);
        end

        // A fresh start afterwards must restart numbering at zero.
        for (int i = 0; i < 10; i++)
        begin
            for (int k = 0; k < 4; k++)
                p[k] = pool_pick(base, 6);
            add_constraint(i == 0, pick_body_count(), p[0], p[1], p[2], p[3], i == 0);
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Drain: all requests sent and every expected result taken.
        do
            @(negedge clk);
        while (pending_q.size() != 0 || req_if.valid || coloring_q.size() != 0);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (mismatches == 0 && coloring_q.size() == 0)
            $display("PASS constraint_group_coloring");
        else
            $display("FAIL constraint_group_coloring");
        $finish;
    end

endmodule

[constraint_group_coloring.f]
hw/rtl/cgc_pkg.sv
hw/rtl/cgc_if.sv
hw/rtl/cgc_mask_ram.sv
hw/rtl/cgc_group_find.sv
hw/rtl/constraint_group_coloring.sv
hw/rtl/cgc_checker.sv
test/tb_top.sv
